[hdl/binary_max_heap_priority_queue_macros.svh]
// Assertion macros shared by the heap priority queue RTL.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define BMHPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMHPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/bmhpq_pkg.sv]
// Shared constants and types for the heap priority queue.
`default_nettype none

package bmhpq_pkg;

    localparam int DEF_CAPACITY      = 256;
    localparam int DEF_DATA_BITS     = 32;
    localparam int DEF_PRIORITY_BITS = 16;
    localparam int DEF_COUNT_BITS    = $clog2(DEF_CAPACITY + 1);

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_POP_EMPTY = 2'd1,
        ERR_PUSH_FULL = 2'd2
    } err_code_t;

endpackage

`default_nettype wire

[hdl/bmhpq_req_if.sv]
// Request channel: operation code and the entry to push.
`default_nettype none

interface bmhpq_req_if
    import bmhpq_pkg::*;
#(
    parameter int DATA_BITS     = DEF_DATA_BITS,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [DATA_BITS-1:0]     item_data;
    logic [PRIORITY_BITS-1:0] item_priority;

    modport source (output valid, output func, output item_data, output item_priority,
                    input ready);
    modport sink   (input valid, input func, input item_data, input item_priority,
                    output ready);
endinterface

`default_nettype wire

[hdl/bmhpq_rsp_if.sv]
// Response channel: front entry, count, empty flag and error code.
`default_nettype none

interface bmhpq_rsp_if
    import bmhpq_pkg::*;
#(
    parameter int DATA_BITS     = DEF_DATA_BITS,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
);
    logic                     valid;
    logic                     ready;
    logic [DATA_BITS-1:0]     front_data;
    logic [PRIORITY_BITS-1:0] front_priority;
    logic [COUNT_BITS-1:0]    entry_count;
    logic                     is_empty;
    logic [1:0]               error_code;

    modport source (output valid, output front_data, output front_priority,
                    output entry_count, output is_empty, output error_code,
                    input ready);
    modport sink   (input valid, input front_data, input front_priority,
                    input entry_count, input is_empty, input error_code,
                    output ready);
endinterface

`default_nettype wire

[hdl/bmhpq_heap_ram.sv]
// Heap entry memory: one write port and two registered read ports.
`default_nettype none

module bmhpq_heap_ram
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ENTRY_BITS = DEF_DATA_BITS + DEF_PRIORITY_BITS
)(
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  wire logic [ENTRY_BITS-1:0]       wr_entry,
    input  wire logic [$clog2(CAPACITY)-1:0] rd_addr_a,
    input  wire logic [$clog2(CAPACITY)-1:0] rd_addr_b,
    output logic      [ENTRY_BITS-1:0]       rd_entry_a,
    output logic      [ENTRY_BITS-1:0]       rd_entry_b
);

    logic [ENTRY_BITS-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_a <= mem[rd_addr_a];
        rd_entry_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

[hdl/binary_max_heap_priority_queue.sv]
// A peek, a rejected push or pop, or a pop that empties the queue goes straight to the
// response state; a push sifts up through ST_UP_RD and ST_UP_CMP (and ST_WR_FINAL at the
// root), and any other pop reads the last entry before sifting down in ST_DN_CMP.
// One operation is in flight at a time; the sift walks one heap level per cycle, and a new
// request is taken the cycle after the result is loaded into a free response register.
// Reset empties the queue and clears control; the entry memory itself is not cleared.
`default_nettype none

`include "binary_max_heap_priority_queue_macros.svh"

module binary_max_heap_priority_queue
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY      = DEF_CAPACITY,
    parameter int DATA_BITS     = DEF_DATA_BITS,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmhpq_req_if.sink   req,
    bmhpq_rsp_if.source rsp
);

    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = DATA_BITS + PRIORITY_BITS;
    localparam int IDX_BITS   = ADDR_BITS + 2;
    localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_WR_FINAL,
        ST_DN_RD_LAST,
        ST_DN_LOAD,
        ST_DN_CMP,
        ST_RESP
    } state_t;

    state_t                   state_reg, state_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [ADDR_BITS-1:0]     hole_reg, hole_next;
    logic [DATA_BITS-1:0]     carry_data_reg, carry_data_next;
    logic [PRIORITY_BITS-1:0] carry_prio_reg, carry_prio_next;
    err_code_t                err_reg, err_next;
    logic [DATA_BITS-1:0]     root_data_reg;
    logic [PRIORITY_BITS-1:0] root_prio_reg;

    logic                     rsp_valid_reg;
    logic [DATA_BITS-1:0]     rsp_data_reg;
    logic [PRIORITY_BITS-1:0] rsp_prio_reg;
    logic [COUNT_BITS-1:0]    rsp_count_reg;
    logic                     rsp_empty_reg;
    err_code_t                rsp_err_reg;
    logic                     rsp_load;

    logic                     req_ready;
    logic                     req_accept;

    logic                     wr_en;
    logic [ADDR_BITS-1:0]     wr_addr;
    logic [ENTRY_BITS-1:0]    wr_entry;
    logic [ADDR_BITS-1:0]     rd_addr_a;
    logic [ADDR_BITS-1:0]     rd_addr_b;
    logic [ENTRY_BITS-1:0]    rd_entry_a;
    logic [ENTRY_BITS-1:0]    rd_entry_b;

    logic [PRIORITY_BITS-1:0] rd_a_prio, rd_b_prio;
    logic [ADDR_BITS-1:0]     parent_idx, grand_idx;
    logic [IDX_BITS-1:0]      count_wide;
    logic [IDX_BITS-1:0]      left_idx, right_idx;
    logic                     left_ok, pick_right;
    logic [ADDR_BITS-1:0]     big_idx;
    logic [ENTRY_BITS-1:0]    big_entry;
    logic [PRIORITY_BITS-1:0] big_prio;
    logic [IDX_BITS-1:0]      big_left, big_right;

    bmhpq_heap_ram #(
        .CAPACITY   (CAPACITY),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_ram (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_entry   (wr_entry),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_entry_a (rd_entry_a),
        .rd_entry_b (rd_entry_b)
    );

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req_ready;
    assign req.ready  = req_ready;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.front_data     = rsp_data_reg;
    assign rsp.front_priority = rsp_prio_reg;
    assign rsp.entry_count    = rsp_count_reg;
    assign rsp.is_empty       = rsp_empty_reg;
    assign rsp.error_code     = rsp_err_reg;

    // Entries are stored as {data, priority}.
    assign rd_a_prio = rd_entry_a[PRIORITY_BITS-1:0];
    assign rd_b_prio = rd_entry_b[PRIORITY_BITS-1:0];

    // Heap index arithmetic around the current hole.
    assign parent_idx = (hole_reg - ADDR_BITS'(1)) >> 1;
    assign grand_idx  = (parent_idx - ADDR_BITS'(1)) >> 1;
    assign count_wide = IDX_BITS'(count_reg);
    assign left_idx   = (IDX_BITS'(hole_reg) << 1) + IDX_BITS'(1);
    assign right_idx  = left_idx + IDX_BITS'(1);
    assign left_ok    = (left_idx < count_wide);
    // The left child wins a tie between the two children.
    assign pick_right = (right_idx < count_wide) && (rd_b_prio > rd_a_prio);
    assign big_idx    = pick_right ? right_idx[ADDR_BITS-1:0] : left_idx[ADDR_BITS-1:0];
    assign big_entry  = pick_right ? rd_entry_b : rd_entry_a;
    assign big_prio   = big_entry[PRIORITY_BITS-1:0];
    assign big_left   = (IDX_BITS'(big_idx) << 1) + IDX_BITS'(1);
    assign big_right  = big_left + IDX_BITS'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        hole_next       = hole_reg;
        carry_data_next = carry_data_reg;
        carry_prio_next = carry_prio_reg;
        err_next        = err_reg;
        wr_en           = 1'b0;
        wr_addr         = hole_reg;
        wr_entry        = {carry_data_reg, carry_prio_reg};
        rd_addr_a       = '0;
        rd_addr_b       = '0;
        rsp_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    err_next = ERR_OK;
                    case (req.func)
                        FUNC_PUSH:
                        begin
                            if (count_reg == CAP_COUNT)
                            begin
                                err_next   = ERR_PUSH_FULL;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                carry_data_next = req.item_data;
                                carry_prio_next = req.item_priority;
                                hole_next       = count_reg[ADDR_BITS-1:0];
                                count_next      = count_reg + COUNT_BITS'(1);
                                state_next      = ST_UP_RD;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next   = ERR_POP_EMPTY;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                count_next = count_reg - COUNT_BITS'(1);
                                hole_next  = '0;
                                if (count_reg == COUNT_BITS'(1))
                                begin
                                    state_next = ST_RESP;
                                end
                                else
                                begin
                                    state_next = ST_DN_RD_LAST;
                                end
                            end
                        end
                        FUNC_PEEK:
                        begin
                            state_next = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_UP_RD:
            begin
                if (hole_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    rd_addr_a  = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_a_prio < carry_prio_reg)
                begin
                    // Parent moves down into the hole; the hole moves up.
                    wr_entry  = rd_entry_a;
                    hole_next = parent_idx;
                    if (parent_idx == '0)
                    begin
                        state_next = ST_WR_FINAL;
                    end
                    else
                    begin
                        rd_addr_a = grand_idx;
                    end
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_WR_FINAL:
            begin
                wr_en      = 1'b1;
                state_next = ST_RESP;
            end

            ST_DN_RD_LAST:
            begin
                // The count has already dropped, so it indexes the last entry.
                rd_addr_a  = count_reg[ADDR_BITS-1:0];
                state_next = ST_DN_LOAD;
            end

            ST_DN_LOAD:
            begin
                carry_data_next = rd_entry_a[ENTRY_BITS-1:PRIORITY_BITS];
                carry_prio_next = rd_a_prio;
                rd_addr_a       = left_idx[ADDR_BITS-1:0];
                rd_addr_b       = right_idx[ADDR_BITS-1:0];
                state_next      = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (left_ok && (carry_prio_reg < big_prio))
                begin
                    // Bigger child moves up into the hole; the hole moves down.
                    wr_entry  = big_entry;
                    hole_next = big_idx;
                    rd_addr_a = big_left[ADDR_BITS-1:0];
                    rd_addr_b = big_right[ADDR_BITS-1:0];
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            hole_reg       <= '0;
            carry_data_reg <= '0;
            carry_prio_reg <= '0;
            err_reg        <= ERR_OK;
            root_data_reg  <= '0;
            root_prio_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_count_reg  <= '0;
            rsp_err_reg    <= ERR_OK;
            rsp_empty_reg  <= 1'b1;
            rsp_data_reg   <= '0;
            rsp_prio_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hole_reg       <= hole_next;
            carry_data_reg <= carry_data_next;
            carry_prio_reg <= carry_prio_next;
            err_reg        <= err_next;

            // Keep a copy of the root so the front entry needs no memory read.
            if (wr_en && (wr_addr == '0))
            begin
                root_data_reg <= wr_entry[ENTRY_BITS-1:PRIORITY_BITS];
                root_prio_reg <= wr_entry[PRIORITY_BITS-1:0];
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_count_reg <= count_reg;
                rsp_err_reg   <= err_reg;
                rsp_empty_reg <= (count_reg == '0);
                rsp_data_reg  <= (count_reg == '0) ? '0 : root_data_reg;
                rsp_prio_reg  <= (count_reg == '0) ? '0 : root_prio_reg;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    `BMHPQ_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= CAP_COUNT, "entry count above capacity")
    `BMHPQ_ASSERT_NEXT(a_push_grows, req_accept && (req.func == FUNC_PUSH) && (count_reg != CAP_COUNT), count_reg == $past(count_reg) + COUNT_BITS'(1), "accepted push did not add an entry")
    `BMHPQ_ASSERT_SAME(a_no_write_idle, (state_reg == ST_IDLE) || (state_reg == ST_RESP), !wr_en, "memory written outside an operation")
    `BMHPQ_ASSERT_SAME(a_full_flag, rsp_valid_reg && (rsp_err_reg == ERR_PUSH_FULL), rsp_count_reg == CAP_COUNT, "full error reported below capacity")
    `BMHPQ_ASSERT_SAME(a_empty_front, rsp_valid_reg && rsp_empty_reg, (rsp_count_reg == '0) && (rsp_prio_reg == '0) && (rsp_data_reg == '0), "empty result carries an entry")

endmodule

`default_nettype wire

[tb/binary_max_heap_priority_queue_tb.sv]
// Self-checking testbench for the binary max-heap priority queue with a built-in heap model.
module binary_max_heap_priority_queue_tb;
    import bmhpq_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int DATA_BITS     = DEF_DATA_BITS;
    localparam int PRIORITY_BITS = DEF_PRIORITY_BITS;
    localparam int COUNT_BITS    = DEF_COUNT_BITS;

    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam int PHASE_ITEMS   = 610;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [DATA_BITS-1:0]     front_data;
        logic [PRIORITY_BITS-1:0] front_priority;
        logic [COUNT_BITS-1:0]    entry_count;
        logic                     is_empty;
        err_code_t                error;
    } front_status_t;

    typedef enum int {
        LOAD_FILL,
        LOAD_DRAIN,
        LOAD_MIX
    } load_mode_t;

    class heap_scoreboard;
        logic [DATA_BITS-1:0]     slot_data [CAPACITY];
        logic [PRIORITY_BITS-1:0] slot_priority [CAPACITY];
        int unsigned              fill_count;
        int unsigned              peak_fill;
        front_status_t            expected_fronts [$];
        int unsigned              pushes, pops, peeks, spares;
        int unsigned              full_pushes, empty_pops;
        int unsigned              checked, mismatches, unexpected;

        function void swap_slots(int a, int b);
            logic [DATA_BITS-1:0]     d;
            logic [PRIORITY_BITS-1:0] p;
            d = slot_data[a];
            p = slot_priority[a];
            slot_data[a] = slot_data[b];
            slot_priority[a] = slot_priority[b];
            slot_data[b] = d;
            slot_priority[b] = p;
        endfunction

        // Applies one accepted transaction to the heap copy and queues the front it implies.
        function void note_request(logic [1:0] op, logic [DATA_BITS-1:0] data,
                                   logic [PRIORITY_BITS-1:0] prio);
            front_status_t want;
            int            pos, parent, left, right, big;
            want.error = ERR_OK;
            if (op == FUNC_PUSH)
            begin
                pushes++;
                if (fill_count >= CAPACITY)
                begin
                    want.error = ERR_PUSH_FULL;
                    full_pushes++;
                end
                else
                begin
                    pos = fill_count;
                    slot_data[pos] = data;
                    slot_priority[pos] = prio;
                    fill_count++;
                    while (pos != 0)
                    begin
                        parent = (pos - 1) / 2;
                        if (slot_priority[parent] >= slot_priority[pos])
                            break;
                        swap_slots(pos, parent);
                        pos = parent;
                    end
                end
            end
            else if (op == FUNC_POP)
            begin
                pops++;
                if (fill_count == 0)
                begin
                    want.error = ERR_POP_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    fill_count--;
                    if (fill_count != 0)
                    begin
                        slot_data[0] = slot_data[fill_count];
                        slot_priority[0] = slot_priority[fill_count];
                        pos = 0;
                        forever
                        begin
                            left = 2 * pos + 1;
                            right = left + 1;
                            if (left >= fill_count)
                                break;
                            big = left;
                            // The left child wins a tie between the two children.
                            if (right < fill_count && slot_priority[right] > slot_priority[left])
                                big = right;
                            if (slot_priority[pos] >= slot_priority[big])
                                break;
                            swap_slots(pos, big);
                            pos = big;
                        end
                    end
                end
            end
            else if (op == FUNC_PEEK)
            begin
                peeks++;
            end
            else
            begin
                spares++;
            end

            if (fill_count > peak_fill)
                peak_fill = fill_count;
            if (fill_count == 0)
            begin
                want.front_data = '0;
                want.front_priority = '0;
                want.is_empty = 1'b1;
            end
            else
            begin
                want.front_data = slot_data[0];
                want.front_priority = slot_priority[0];
                want.is_empty = 1'b0;
            end
            want.entry_count = COUNT_BITS'(fill_count);
            expected_fronts.push_back(want);
        endfunction

        function void check_front(front_status_t got);
            front_status_t want;
            logic          bad;
            if (expected_fronts.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= REPORT_LIMIT)
                    $display("ERROR: result with no transaction outstanding: data %h prio %h count %0d empty %0d err %0d",
                             got.front_data, got.front_priority, got.entry_count,
                             got.is_empty, got.error);
                return;
            end
            want = expected_fronts.pop_front();
            checked++;
            bad = (got.front_data !== want.front_data)
                || (got.front_priority !== want.front_priority)
                || (got.entry_count !== want.entry_count)
                || (got.is_empty !== want.is_empty)
                || (got.error !== want.error);
            if (bad)
            begin
                mismatches++;
                if (mismatches + unexpected <= REPORT_LIMIT)
                    $display("ERROR: result %0d: expected data %h prio %h count %0d empty %0d err %0d, got data %h prio %h count %0d empty %0d err %0d",
                             checked, want.front_data, want.front_priority, want.entry_count,
                             want.is_empty, want.error, got.front_data, got.front_priority,
                             got.entry_count, got.is_empty, got.error);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    heap_scoreboard sb = new();

    bmhpq_req_if req_ch ();
    bmhpq_rsp_if rsp_ch ();

    binary_max_heap_priority_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // Holds valid high from one transaction to the next unless an idle gap is drawn.
    task automatic send_request(input logic [1:0] op, input logic [DATA_BITS-1:0] data,
                                input logic [PRIORITY_BITS-1:0] prio);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= op;
        req_ch.item_data <= data;
        req_ch.item_priority <= prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(op, data, prio);
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_front('{front_data: rsp_ch.front_data,
                                 front_priority: rsp_ch.front_priority,
                                 entry_count: rsp_ch.entry_count,
                                 is_empty: rsp_ch.is_empty,
                                 error: err_code_t'(rsp_ch.error_code)});
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5000000;
        $display("ERROR: timeout with %0d results outstanding", sb.expected_fronts.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        load_mode_t               mode;
        int unsigned              full_mark, empty_mark;
        int                       mix_left, pick, phase, i;
        logic [1:0]               op;
        logic [DATA_BITS-1:0]     data;
        logic [PRIORITY_BITS-1:0] prio;

        send_idle_pct = 26;
        recv_idle_pct = 52;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FUNC_PEEK;
        req_ch.item_data <= '0;
        req_ch.item_priority <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-queue cases, field extremes, equal priorities and the spare code.
        send_request(FUNC_PEEK, '0, '0);
        send_request(FUNC_POP, '1, '1);
        send_request(FUNC_SPARE, '1, '1);
        send_request(FUNC_PUSH, 32'h0000_0000, 16'h0000);
        send_request(FUNC_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(FUNC_PUSH, 32'hA5A5_A5A5, 16'hFFFF);
        send_request(FUNC_PUSH, 32'h5A5A_5A5A, 16'h8000);
        send_request(FUNC_PUSH, 32'h1234_5678, 16'h8000);
        send_request(FUNC_PEEK, '0, '0);
        send_request(FUNC_SPARE, '0, '0);
        repeat (6) send_request(FUNC_POP, '0, '0);
        send_request(FUNC_PUSH, 32'hFFFF_FFFF, 16'h0000);
        send_request(FUNC_PUSH, 32'h0000_0000, 16'hFFFF);
        send_request(FUNC_PUSH, 32'h0F0F_0F0F, 16'h0000);
        send_request(FUNC_POP, '0, '0);
        send_request(FUNC_POP, '0, '0);
        send_request(FUNC_POP, '0, '0);

        // Random traffic swings the fill level between empty and full so both
        // rejection cases and deep sifts keep occurring.
        mode = LOAD_FILL;
        full_mark = sb.full_pushes;
        empty_mark = sb.empty_pops;
        mix_left = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 26 : 0;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (mode == LOAD_FILL && sb.full_pushes >= full_mark + 3)
                begin
                    mode = LOAD_DRAIN;
                    empty_mark = sb.empty_pops;
                end
                else if (mode == LOAD_DRAIN && sb.empty_pops >= empty_mark + 3)
                begin
                    mode = LOAD_MIX;
                    mix_left = $urandom_range(60, 150);
                end
                else if (mode == LOAD_MIX && mix_left == 0)
                begin
                    mode = LOAD_FILL;
                    full_mark = sb.full_pushes;
                end

                pick = $urandom_range(0, 99);
                if (pick < ((mode == LOAD_FILL) ? 78 : (mode == LOAD_DRAIN) ? 12 : 45))
                    op = FUNC_PUSH;
                else if (pick < 90)
                    op = FUNC_POP;
                else if (pick < 97)
                    op = FUNC_PEEK;
                else
                    op = FUNC_SPARE;

                case ($urandom_range(0, 9))
                    0: data = '0;
                    1: data = '1;
                    default: data = $urandom;
                endcase
                // Narrow priorities are frequent so that ties show up along the sift paths.
                case ($urandom_range(0, 9))
                    0: prio = '0;
                    1: prio = '1;
                    2, 3, 4: prio = PRIORITY_BITS'($urandom_range(0, 7));
                    default: prio = PRIORITY_BITS'($urandom);
                endcase

                send_request(op, data, prio);
                if (mode == LOAD_MIX)
                    mix_left--;
            end
        end

        req_ch.valid <= 1'b0;
        while (sb.expected_fronts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d pushes, %0d pops, %0d peeks and %0d spare-code transactions; peak fill %0d of %0d.",
                 sb.pushes, sb.pops, sb.peeks, sb.spares, sb.peak_fill, CAPACITY);
        $display("Saw %0d pushes on a full queue and %0d pops on an empty one; %0d results checked, %0d mismatches, %0d unexpected.",
                 sb.full_pushes, sb.empty_pops, sb.checked, sb.mismatches, sb.unexpected);
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.expected_fronts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
